// ===== rtl/gkt_pkg.sv =====
// Package: Greek keyboard transliteration types, constants and letter lookup functions.
package gkt_pkg;

  localparam int CP_W   = 16;
  localparam int IDX_W  = 6;
  localparam int KIND_W = 2;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // case_mode codes
  localparam logic [1:0] CM_LOWER = 2'd1;
  localparam logic [1:0] CM_UPPER = 2'd2;

  // pending stage codes
  localparam logic [1:0] PS_NONE  = 2'd0;
  localparam logic [1:0] PS_HELD  = 2'd1;
  localparam logic [1:0] PS_DIAER = 2'd2;

  // token kinds
  localparam logic [KIND_W-1:0] TK_CP     = 2'd0;
  localparam logic [KIND_W-1:0] TK_RAW    = 2'd1;
  localparam logic [KIND_W-1:0] TK_NOCONV = 2'd2;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_S_LOWER = 8'h73;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] LO_IDX_OFS = 8'd71;  // 'a' - 26

  localparam logic [CP_W-1:0] CP_FINAL_SIGMA = 16'h03C2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CP_W-1:0]   val;
  } tok_t;

  typedef struct packed {
    tok_t tok0;
    logic tok1_vld;
    tok_t tok1;
    logic eow;
  } job_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic [CP_W-1:0] base_cp(input logic [IDX_W-1:0] idx);
    logic [CP_W-1:0] r;
    case (idx)
      6'd0:  r = 16'h0391;  6'd1:  r = 16'h0392;  6'd2:  r = 16'h03A8;
      6'd3:  r = 16'h0394;  6'd4:  r = 16'h0395;  6'd5:  r = 16'h03A6;
      6'd6:  r = 16'h0393;  6'd7:  r = 16'h0397;  6'd8:  r = 16'h0399;
      6'd9:  r = 16'h039E;  6'd10: r = 16'h039A;  6'd11: r = 16'h039B;
      6'd12: r = 16'h039C;  6'd13: r = 16'h039D;  6'd14: r = 16'h039F;
      6'd15: r = 16'h03A0;  6'd16: r = 16'h2015;  6'd17: r = 16'h03A1;
      6'd18: r = 16'h03A3;  6'd19: r = 16'h03A4;  6'd20: r = 16'h0398;
      6'd21: r = 16'h03A9;  6'd22: r = 16'h03A3;  6'd23: r = 16'h03A7;
      6'd24: r = 16'h03A5;  6'd25: r = 16'h0396;
      6'd26: r = 16'h03B1;  6'd27: r = 16'h03B2;  6'd28: r = 16'h03C8;
      6'd29: r = 16'h03B4;  6'd30: r = 16'h03B5;  6'd31: r = 16'h03C6;
      6'd32: r = 16'h03B3;  6'd33: r = 16'h03B7;  6'd34: r = 16'h03B9;
      6'd35: r = 16'h03BE;  6'd36: r = 16'h03BA;  6'd37: r = 16'h03BB;
      6'd38: r = 16'h03BC;  6'd39: r = 16'h03BD;  6'd40: r = 16'h03BF;
      6'd41: r = 16'h03C0;  6'd42: r = 16'h00B7;  6'd43: r = 16'h03C1;
      6'd44: r = 16'h03C3;  6'd45: r = 16'h03C4;  6'd46: r = 16'h03B8;
      6'd47: r = 16'h03C9;  6'd48: r = 16'h03C2;  6'd49: r = 16'h03C7;
      6'd50: r = 16'h03C5;  6'd51: r = 16'h03B6;
      default: r = '0;
    endcase
    return r;
  endfunction

  // zero: letter has no accented variants
  function automatic logic [CP_W-1:0] acute_cp(input logic [IDX_W-1:0] idx);
    logic [CP_W-1:0] r;
    case (idx)
      6'd0:  r = 16'h0386;  6'd4:  r = 16'h0388;  6'd7:  r = 16'h0389;
      6'd8:  r = 16'h038A;  6'd14: r = 16'h038C;  6'd21: r = 16'h038F;
      6'd24: r = 16'h038E;
      6'd26: r = 16'h03AC;  6'd30: r = 16'h03AD;  6'd33: r = 16'h03AE;
      6'd34: r = 16'h03AF;  6'd40: r = 16'h03CC;  6'd47: r = 16'h03CE;
      6'd50: r = 16'h03CD;
      default: r = '0;
    endcase
    return r;
  endfunction

  // sel 0: diaeresis, sel 1: diaeresis with acute
  function automatic logic [CP_W-1:0] diaer_cp(input logic [IDX_W-1:0] idx,
                                               input logic sel);
    logic [CP_W-1:0] r;
    case (idx)
      6'd8:    r = 16'h03AA;
      6'd24:   r = 16'h03AB;
      6'd34:   r = sel ? 16'h0390 : 16'h03CA;
      6'd50:   r = sel ? 16'h03B0 : 16'h03CB;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gkt_front.sv =====
// Front end: word tracking, case mapping, pending-letter logic, job building.
module gkt_front import gkt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_word,
  output logic       job_vld,
  output job_t       job
);

  logic [1:0]       case_mode_r;
  logic [IDX_W-1:0] pend_r, pend_nxt;
  logic [1:0]       stage_r, stage_nxt;
  logic             start_r, start_nxt;
  logic             rej_r, rej_nxt;

  always_comb begin
    logic [7:0] c;
    logic       rej;
    logic       consumed;
    logic       pre_vld, main_vld, post_vld;
    tok_t       pre_tok, main_tok, post_tok;
    logic [IDX_W-1:0] idx;

    pend_nxt  = pend_r;
    stage_nxt = stage_r;
    start_nxt = start_r;
    rej_nxt   = rej_r;
    consumed  = 1'b0;
    pre_vld   = 1'b0;
    main_vld  = 1'b0;
    post_vld  = 1'b0;
    pre_tok   = '{kind: TK_CP, val: '0};
    main_tok  = '{kind: TK_CP, val: '0};
    post_tok  = '{kind: TK_CP, val: '0};
    job_vld   = 1'b0;
    job       = '0;

    rej = start_r ? !is_letter(in_byte) : rej_r;

    c = in_byte;
    if (case_mode_r == CM_LOWER && in_byte >= CH_UP_A && in_byte <= CH_UP_Z) begin
      c = in_byte + CASE_BIT;
    end else if (case_mode_r == CM_UPPER && in_byte >= CH_LO_A && in_byte <= CH_LO_Z) begin
      c = in_byte - CASE_BIT;
    end
    idx = (c >= CH_LO_A) ? IDX_W'(c - LO_IDX_OFS) : IDX_W'(c - CH_UP_A);

    if (rej) begin
      if (in_end_of_word) begin
        job_vld   = 1'b1;
        job.tok0  = '{kind: TK_NOCONV, val: '0};
        job.eow   = 1'b1;
        start_nxt = 1'b1;
        rej_nxt   = 1'b0;
        stage_nxt = PS_NONE;
      end else begin
        start_nxt = 1'b0;
        rej_nxt   = 1'b1;
      end
    end else begin
      start_nxt = 1'b0;
      rej_nxt   = 1'b0;
      stage_nxt = PS_NONE;
      case (stage_r)
        PS_HELD: begin
          if (in_byte == CH_COLON && diaer_cp(pend_r, 1'b0) != '0) begin
            stage_nxt = PS_DIAER;
            consumed  = 1'b1;
          end else if (in_byte == CH_APOS) begin
            pre_vld     = 1'b1;
            pre_tok.val = acute_cp(pend_r);
            consumed    = 1'b1;
          end else begin
            pre_vld     = 1'b1;
            pre_tok.val = base_cp(pend_r);
          end
        end
        PS_DIAER: begin
          pre_vld     = 1'b1;
          pre_tok.val = diaer_cp(pend_r, in_byte == CH_APOS);
          consumed    = (in_byte == CH_APOS);
        end
        default: ;
      endcase

      if (!consumed) begin
        if (c == CH_S_LOWER && in_end_of_word) begin
          main_vld     = 1'b1;
          main_tok.val = CP_FINAL_SIGMA;
        end else if (is_letter(c)) begin
          if (acute_cp(idx) != '0) begin
            pend_nxt  = idx;
            stage_nxt = PS_HELD;
          end else begin
            main_vld     = 1'b1;
            main_tok.val = base_cp(idx);
          end
        end else begin
          main_vld      = 1'b1;
          main_tok.kind = TK_RAW;
          main_tok.val  = CP_W'(in_byte);
        end
      end

      if (in_end_of_word) begin
        if (stage_nxt == PS_HELD) begin
          post_vld     = 1'b1;
          post_tok.val = base_cp(pend_nxt);
        end else if (stage_nxt == PS_DIAER) begin
          post_vld     = 1'b1;
          post_tok.val = diaer_cp(pend_nxt, 1'b0);
        end
        stage_nxt = PS_NONE;
        start_nxt = 1'b1;
      end

      // at most two of pre, main, post are present
      job.eow = in_end_of_word;
      if (pre_vld) begin
        job.tok0     = pre_tok;
        job.tok1_vld = main_vld | post_vld;
        job.tok1     = main_vld ? main_tok : post_tok;
      end else begin
        job.tok0     = main_vld ? main_tok : post_tok;
        job.tok1_vld = main_vld & post_vld;
        job.tok1     = post_tok;
      end
      job_vld = pre_vld | main_vld | post_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r <= '0;
      pend_r      <= '0;
      stage_r     <= PS_NONE;
      start_r     <= 1'b1;
      rej_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case_mode_r <= cfg_wr_data;
      end
      if (accept) begin
        pend_r  <= pend_nxt;
        stage_r <= stage_nxt;
        start_r <= start_nxt;
        rej_r   <= rej_nxt;
      end
    end
  end

endmodule

// ===== rtl/gkt_queue.sv =====
// Job queue between front and back ends.
module gkt_queue import gkt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gkt_back.sv =====
// Back end: serializes a job's tokens into UTF-8 bytes on the output register.
module gkt_back import gkt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_word_done,
  output logic       out_no_conversion
);

  job_t       cur_r;
  logic       cur_vld_r;
  logic       tok_sel_r;
  logic [1:0] byte_idx_r;
  logic       out_vld_r;
  logic [7:0] byte_r;
  logic       done_r, noconv_r;

  tok_t       tok;
  logic [1:0] last_idx;
  logic       tok_last, job_last, adv;
  logic [7:0] byte_nxt;

  assign tok      = tok_sel_r ? cur_r.tok1 : cur_r.tok0;
  assign last_idx = (tok.kind != TK_CP) ? 2'd0 :
                    (tok.val[CP_W-1:11] != '0) ? 2'd2 : 2'd1;
  assign tok_last = (byte_idx_r == last_idx);
  assign job_last = tok_last && (tok_sel_r || !cur_r.tok1_vld);
  assign adv      = cur_vld_r && (!out_vld_r || out_ready);
  assign q_pop    = !q_empty && (!cur_vld_r || (adv && job_last));

  always_comb begin
    byte_nxt = '0;
    case (tok.kind)
      TK_RAW: byte_nxt = tok.val[7:0];
      TK_CP: begin
        if (last_idx == 2'd2) begin
          case (byte_idx_r)
            2'd0:    byte_nxt = {4'hE, tok.val[15:12]};
            2'd1:    byte_nxt = {2'b10, tok.val[11:6]};
            default: byte_nxt = {2'b10, tok.val[5:0]};
          endcase
        end else begin
          byte_nxt = (byte_idx_r == 2'd0) ? {3'b110, tok.val[10:6]}
                                          : {2'b10, tok.val[5:0]};
        end
      end
      default: byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r   <= byte_nxt;
      done_r   <= job_last && cur_r.eow;
      noconv_r <= (tok.kind == TK_NOCONV);
    end
    if (q_pop) begin
      cur_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      tok_sel_r  <= 1'b0;
      byte_idx_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (q_pop) begin
        cur_vld_r  <= 1'b1;
        tok_sel_r  <= 1'b0;
        byte_idx_r <= '0;
      end else if (adv) begin
        if (job_last) begin
          cur_vld_r <= 1'b0;
        end else if (tok_last) begin
          tok_sel_r  <= 1'b1;
          byte_idx_r <= '0;
        end else begin
          byte_idx_r <= byte_idx_r + 1'b1;
        end
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_byte          = byte_r;
  assign out_word_done     = done_r;
  assign out_no_conversion = noconv_r;

endmodule

// ===== rtl/greek_keyboard_translit_utf8.sv =====
// Top level: Greek keyboard transliteration of ASCII words into UTF-8 bytes.
// Throughput: one input beat per cycle while the four-entry job queue has room;
// the back end emits one byte per cycle while out_ready is high; a letter takes two or three bytes.
// Reset (rst_n low, synchronous): case_mode to keep, no letter held, word start,
// queue and output register empty.
module greek_keyboard_translit_utf8 import gkt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: case_mode
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  // input beats
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_word,
  // result beats
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_word_done,
  output logic       out_no_conversion
);

  logic accept;
  logic job_vld;
  job_t job;
  logic q_full, q_empty, q_pop;
  job_t q_job;

  // A beat is taken whenever the queue can hold the job it may create.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Front: classifies each byte, tracks held letter and word state,
  // and builds a job of at most two tokens (code point, raw byte or no-conversion flag).
  gkt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_word (in_end_of_word),
    .job_vld        (job_vld),
    .job            (job)
  );

  // Short queue decouples input acceptance from byte serialization.
  gkt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && job_vld),
    .push_job (job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_job)
  );

  // Back: expands tokens into UTF-8 bytes through the output register.
  gkt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_job             (q_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_word_done     (out_word_done),
    .out_no_conversion (out_no_conversion)
  );

endmodule

// ===== tb/greek_keyboard_translit_utf8_test.sv =====
// Testbench for the Greek keyboard transliterator: predicted UTF-8 beats checked under stalls.
module greek_keyboard_translit_utf8_test import gkt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // case_mode values the package leaves unnamed
  localparam logic [1:0] CM_KEEP  = 2'd0;
  localparam logic [1:0] CM_SPARE = 2'd3;  // unused code, behaves as keep

  // key indexes of the letters that take a diaeresis
  localparam logic [5:0] KEY_UP_I = 6'd8;
  localparam logic [5:0] KEY_UP_Y = 6'd24;
  localparam logic [5:0] KEY_LO_I = 6'd34;
  localparam logic [5:0] KEY_LO_Y = 6'd50;

  localparam int SETTLE_CYCLES = 8;        // margin for held work to drain
  localparam int TIMEOUT_NS    = 3000000;  // far beyond the slowest run
  localparam int PHASE_ITEMS   = 90;

  // Plain forms, A..Z then a..z
  localparam logic [15:0] PLAIN_CP [52] = '{
    16'h0391, 16'h0392, 16'h03A8, 16'h0394, 16'h0395, 16'h03A6, 16'h0393, 16'h0397,
    16'h0399, 16'h039E, 16'h039A, 16'h039B, 16'h039C, 16'h039D, 16'h039F, 16'h03A0,
    16'h2015, 16'h03A1, 16'h03A3, 16'h03A4, 16'h0398, 16'h03A9, 16'h03A3, 16'h03A7,
    16'h03A5, 16'h0396,
    16'h03B1, 16'h03B2, 16'h03C8, 16'h03B4, 16'h03B5, 16'h03C6, 16'h03B3, 16'h03B7,
    16'h03B9, 16'h03BE, 16'h03BA, 16'h03BB, 16'h03BC, 16'h03BD, 16'h03BF, 16'h03C0,
    16'h00B7, 16'h03C1, 16'h03C3, 16'h03C4, 16'h03B8, 16'h03C9, 16'h03C2, 16'h03C7,
    16'h03C5, 16'h03B6
  };

  // Tonos forms; zero marks a key that is never held
  localparam logic [15:0] ACUTE_CP [52] = '{
    16'h0386, 16'h0000, 16'h0000, 16'h0000, 16'h0388, 16'h0000, 16'h0000, 16'h0389,
    16'h038A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h038C, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h038F, 16'h0000, 16'h0000,
    16'h038E, 16'h0000,
    16'h03AC, 16'h0000, 16'h0000, 16'h0000, 16'h03AD, 16'h0000, 16'h0000, 16'h03AE,
    16'h03AF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h03CC, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h03CE, 16'h0000, 16'h0000,
    16'h03CD, 16'h0000
  };

  typedef struct packed {
    logic [7:0] octet;
    logic       done;
    logic       noconv;
  } utf8_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_word = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_word_done;
  logic       out_no_conversion;

  greek_keyboard_translit_utf8 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_word   (in_end_of_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_word_done    (out_word_done),
    .out_no_conversion(out_no_conversion)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // UTF-8 beats the block still owes us, oldest first
  utf8_beat_t utf8_due [$];
  int         error_count = 0;

  // Shadow of the transliterator state
  logic [1:0] case_shadow = CM_KEEP;
  logic [5:0] held_key    = '0;
  logic [1:0] held_stage  = PS_NONE;
  logic       word_fresh  = 1'b1;
  logic       word_bad    = 1'b0;

  // Scratch for the bytes one input beat produces
  logic [7:0] step_bytes [6];
  int         step_n;

  // Idle knobs; stall_pct and the hold request are picked up by the receiver process
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_len      = 0;
  logic hold_trigger  = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;

  string accent_keys = "AEHIOVYaehiovy";

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

  // Dialytika form, or dialytika plus tonos; zero for keys without one
  function automatic logic [15:0] dialytika_cp(input logic [5:0] key, input logic tonos);
    case (key)
      KEY_UP_I: return 16'h03AA;
      KEY_UP_Y: return 16'h03AB;
      KEY_LO_I: return tonos ? 16'h0390 : 16'h03CA;
      KEY_LO_Y: return tonos ? 16'h03B0 : 16'h03CB;
      default:  return 16'h0000;
    endcase
  endfunction

  task automatic put_raw(input logic [7:0] b);
    step_bytes[step_n] = b;
    step_n++;
  endtask

  // Encode one code point, two bytes below U+0800 and three above
  task automatic put_utf8(input logic [15:0] cp);
    if (cp < 16'h0800) begin
      put_raw({3'b110, cp[10:6]});
      put_raw({2'b10, cp[5:0]});
    end else begin
      put_raw({4'b1110, cp[15:12]});
      put_raw({2'b10, cp[11:6]});
      put_raw({2'b10, cp[5:0]});
    end
  endtask

  // Advance the shadow state by one accepted beat and queue the bytes it yields
  task automatic translit_byte(input logic [7:0] b, input logic eow);
    logic [7:0] c;
    logic [7:0] k8;
    logic [5:0] key;
    logic       taken;
    step_n = 0;
    taken  = 1'b0;
    if (word_fresh) begin
      word_fresh = 1'b0;
      word_bad   = !is_alpha(b);
    end
    // word that opened with a non-letter: silent until its end, then one flag beat
    if (word_bad) begin
      if (eow) begin
        utf8_due.push_back('{8'h00, 1'b1, 1'b1});
        word_fresh = 1'b1;
        word_bad   = 1'b0;
        held_stage = PS_NONE;
      end
      return;
    end
    c = b;
    if (case_shadow == CM_LOWER && c >= CH_UP_A && c <= CH_UP_Z)
      c = c | CASE_BIT;
    else if (case_shadow == CM_UPPER && c >= CH_LO_A && c <= CH_LO_Z)
      c = c & ~CASE_BIT;
    // resolve a held vowel; ':' and apostrophe test the raw byte
    case (held_stage)
      PS_HELD: begin
        if (b == CH_COLON && dialytika_cp(held_key, 1'b0) != 16'h0000) begin
          held_stage = PS_DIAER;
          taken = 1'b1;
        end else if (b == CH_APOS) begin
          put_utf8(ACUTE_CP[held_key]);
          held_stage = PS_NONE;
          taken = 1'b1;
        end else begin
          put_utf8(PLAIN_CP[held_key]);
          held_stage = PS_NONE;
        end
      end
      PS_DIAER: begin
        if (b == CH_APOS) begin
          put_utf8(dialytika_cp(held_key, 1'b1));
          taken = 1'b1;
        end else begin
          put_utf8(dialytika_cp(held_key, 1'b0));
        end
        held_stage = PS_NONE;
      end
      default: held_stage = PS_NONE;
    endcase
    if (!taken) begin
      if (c == CH_S_LOWER && eow) begin
        put_utf8(CP_FINAL_SIGMA);
      end else if (is_alpha(c)) begin
        k8  = (c >= CH_LO_A) ? c - LO_IDX_OFS : c - CH_UP_A;
        key = k8[5:0];
        if (ACUTE_CP[key] != 16'h0000) begin
          held_key   = key;
          held_stage = PS_HELD;
        end else begin
          put_utf8(PLAIN_CP[key]);
        end
      end else begin
        put_raw(b);
      end
    end
    // word end flushes whatever is still held
    if (eow) begin
      if (held_stage == PS_HELD)
        put_utf8(PLAIN_CP[held_key]);
      else if (held_stage == PS_DIAER)
        put_utf8(dialytika_cp(held_key, 1'b0));
      held_stage = PS_NONE;
      word_fresh = 1'b1;
      word_bad   = 1'b0;
    end
    for (int i = 0; i < step_n; i++)
      utf8_due.push_back('{step_bytes[i], eow && (i == step_n - 1), 1'b0});
  endtask

  // Offer one beat, with random idle cycles ahead of it; valid stays up on return,
  // so anything that waits afterwards must drop it first (see drop_input)
  task automatic send_char(input logic [7:0] b, input logic eow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_word <= eow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    translit_byte(b, eow);
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender holds off until every owed beat is back, then lets held work drain
  task automatic settle_translator();
    drop_input();
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_case_mode(input logic [1:0] m);
    settle_translator();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    case_shadow = m;
  endtask

  // Random word: mostly letters with accent marks, some noise, some rejected words.
  // Returns how many beats counted toward the item budget.
  task automatic send_random_word(output int sent);
    int         len, style, r, r2;
    logic [7:0] ch;
    style = $urandom_range(99);
    len   = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      r  = $urandom_range(99);
      r2 = $urandom_range(51);
      if (i == 0 && style >= 20)
        r = r % 55;  // well-formed words open with a letter
      if (style < 8 && i == 0) begin
        ch = 8'($urandom_range(255));
        while (is_alpha(ch)) ch = 8'($urandom_range(255));
      end else if (style < 20 || r >= 92) begin
        ch = 8'($urandom_range(255));
      end else if (r < 35) begin
        ch = accent_keys[$urandom_range(13)];
      end else if (r < 55) begin
        ch = (r2 < 26) ? 8'(CH_UP_A + r2) : 8'(CH_LO_A + r2 - 26);
      end else if (r < 70) begin
        ch = CH_COLON;
      end else if (r < 85) begin
        ch = CH_APOS;
      end else begin
        ch = CH_S_LOWER;
      end
      send_char(ch, i == len - 1);
    end
    sent = (style < 8) ? 0 : len;
  endtask

  // Accent forms, word-end flushes, sigma, the three-byte key and rejected words
  task automatic test_accent_forms();
    send_word("A");      // held vowel flushed at word end
    send_word("a'");     // tonos
    send_word("i:'");    // dialytika with tonos
    send_word("y:'");
    send_word("I:");     // dialytika flushed at word end
    send_word("E:");     // no dialytika for E: colon passes through
    send_word("zs");     // final sigma
    send_word("i:Q");    // five beats from one input beat
    send_word("oO'");    // held vowel displaced by another
    send_word("b'");     // apostrophe after a plain letter
    send_word("1a");     // rejected word
    send_char(8'h00, 1'b1);
    send_char(8'h68, 1'b0);  // 'h' held, then high bytes pass through
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  // Same words under every case_mode value, including the unused one
  task automatic test_case_modes();
    logic [1:0] modes [4];
    modes = '{CM_LOWER, CM_UPPER, CM_SPARE, CM_KEEP};
    foreach (modes[m]) begin
      set_case_mode(modes[m]);
      send_word("AbS");
      send_word("eS");
      send_word("qI:'");
      send_word("Ss");
    end
  endtask

  task automatic test_random_words(input int idle_pct, input int stall);
    int done_items, n;
    done_items = 0;
    stall_pct <= stall;
    send_idle_pct = idle_pct;
    set_case_mode(2'($urandom_range(2)));
    while (done_items < PHASE_ITEMS) begin
      send_random_word(n);
      done_items += n;
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the job
  // queue fills and in_ready drops; then the sender waits for the backlog
  task automatic test_backpressure();
    int done_items, n;
    done_items = 0;
    stall_pct <= 0;
    send_idle_pct = 0;
    hold_len     <= 400;
    hold_trigger <= ~hold_trigger;
    while (done_items < 40) begin
      send_random_word(n);
      done_items += n;
    end
    settle_translator();
  endtask

  // Result side: random stalls, plus the long hold when one is requested
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted result beat against the oldest owed beat
  always @(posedge clk) begin : check_beats
    utf8_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_due.size() == 0) begin
        $error("unexpected beat: out_byte %h", out_byte);
        error_count++;
      end else begin
        want = utf8_due.pop_front();
        if (out_byte !== want.octet) begin
          $error("out_byte: expected %h, got %h", want.octet, out_byte);
          error_count++;
        end
        if (out_word_done !== want.done) begin
          $error("out_word_done: expected %b, got %b", want.done, out_word_done);
          error_count++;
        end
        if (out_no_conversion !== want.noconv) begin
          $error("out_no_conversion: expected %b, got %b", want.noconv, out_no_conversion);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset value of case_mode (keep) is exercised without a write
    test_accent_forms();
    test_case_modes();
    test_random_words(0, 0);
    test_random_words(54, 0);
    test_random_words(0, 54);
    test_random_words(19, 19);
    test_backpressure();
    settle_translator();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
